// ----- rtl/core/mce3d_pkg.sv -----
package mce3d_pkg;

    // Field widths fixed by the interface
    localparam int unsigned COORD_W = 32;
    localparam int unsigned WORLD_W = 16;

    // Defaults for the core parameters
    localparam int unsigned AXIS_BITS_DEF = 21;
    localparam int unsigned FRAC_BITS_DEF = 8;

    localparam logic [WORLD_W-1:0] WORLD_SIZE_RST = 16'd1000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WORLD_W-1:0]        world_t;

endpackage

// ----- rtl/core/morton_code_3d_encoder_core.sv -----
// 3D Morton encoder core.
//
// Input channel (s_valid/s_ready) takes one point per item: three signed
// coordinates with FRAC_BITS fraction bits. Each axis is mapped from the cube
// centered on the origin with edge world_size onto an AXIS_BITS-bit integer
// (clamped below at 0, saturated at the top), and the three integers are
// interleaved into m_morton_code: x in bit 3k, y in 3k+1, z in 3k+2.
// Output channel (m_valid/m_ready) returns one code per item, in order.
//
// world_size is written through cfg_wr_en/cfg_wr_data; the user writes it only
// while no item is in flight, which the block does not enforce. A value of zero acts as one.
//
// Pipeline: one stage forms the numerator, AXIS_BITS restoring-division
// stages produce one quotient bit each, one stage interleaves into the output
// register. Throughput is one item per cycle while the receiver does not
// stall. Each stage holds its item while the next is occupied and stalled,
// so a stalled receiver fills the pipe and empty stages still take new
// items. Reset (aresetn low, synchronous) empties the pipeline and loads
// world_size with 1000.
module morton_code_3d_encoder_core #(
    parameter int unsigned AXIS_BITS = mce3d_pkg::AXIS_BITS_DEF,
    parameter int unsigned FRAC_BITS = mce3d_pkg::FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  mce3d_pkg::world_t        cfg_wr_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  mce3d_pkg::coord_t        s_coord_x,
    input  mce3d_pkg::coord_t        s_coord_y,
    input  mce3d_pkg::coord_t        s_coord_z,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [3*AXIS_BITS-1:0]   m_morton_code
);

    import mce3d_pkg::*;

    // divisor d = W * 2^(FRAC_BITS+1), numerator n = 2c + W * 2^FRAC_BITS
    localparam int unsigned DW = WORLD_W + FRAC_BITS + 1;
    localparam int unsigned NW = ((DW > COORD_W + 1) ? DW : COORD_W + 1) + 1;
    localparam int unsigned NS = AXIS_BITS + 2;   // stages incl. output register
    localparam int unsigned CW = 3 * AXIS_BITS;

    world_t               world_size_reg;
    world_t               w_eff;
    logic [DW-1:0]        div_d;
    logic [NW-1:0]        w_half;

    logic [NS-1:0]        valid_reg;
    logic [NS:0]          rdy;

    logic [DW-1:0]        rem_reg  [0:2][0:AXIS_BITS];
    logic [DW-1:0]        rem_next [0:2][0:AXIS_BITS];
    logic [AXIS_BITS-1:0] quo_reg  [0:2][0:AXIS_BITS];
    logic [AXIS_BITS-1:0] quo_next [0:2][0:AXIS_BITS];
    logic                 hi_reg   [0:2][0:AXIS_BITS];
    logic                 hi_next  [0:2][0:AXIS_BITS];

    logic [CW-1:0]        code_reg;
    logic [CW-1:0]        code_next;

    coord_t               coord_in [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_size_reg <= WORLD_SIZE_RST;
        end else if (cfg_wr_en) begin
            world_size_reg <= cfg_wr_data;
        end
    end

    assign w_eff  = (world_size_reg == '0) ? WORLD_W'(1) : world_size_reg;
    assign div_d  = DW'(w_eff) << (FRAC_BITS + 1);
    assign w_half = NW'(w_eff) << FRAC_BITS;

    assign coord_in[0] = s_coord_x;
    assign coord_in[1] = s_coord_y;
    assign coord_in[2] = s_coord_z;

    // a stage takes a new item when empty or when its item moves on
    always_comb begin
        rdy[NS] = m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NS-1];

    always_comb begin
        logic signed [NW-1:0] n;
        logic                 lo;
        logic [DW:0]          sh;
        logic                 ge;
        logic [DW:0]          diff;
        logic [AXIS_BITS:0]   qs;
        for (int a = 0; a < 3; a++) begin
            // numerator and range checks
            n  = (NW'(coord_in[a]) <<< 1) + w_half;
            lo = n[NW-1] || (n == '0);
            hi_next[a][0]  = !lo && (n >= NW'(div_d));
            rem_next[a][0] = (lo || hi_next[a][0]) ? '0 : n[DW-1:0];
            quo_next[a][0] = '0;
            // one restoring-division step per stage, quotient MSB first
            for (int k = 1; k <= AXIS_BITS; k++) begin
                sh   = {rem_reg[a][k-1], 1'b0};
                ge   = (sh >= {1'b0, div_d});
                diff = sh - {1'b0, div_d};
                rem_next[a][k] = ge ? diff[DW-1:0] : sh[DW-1:0];
                qs   = {quo_reg[a][k-1], ge};
                quo_next[a][k] = qs[AXIS_BITS-1:0];
                hi_next[a][k]  = hi_reg[a][k-1];
            end
        end
    end

    // saturate and interleave
    always_comb begin
        logic [AXIS_BITS-1:0] q;
        code_next = '0;
        for (int a = 0; a < 3; a++) begin
            q = hi_reg[a][AXIS_BITS] ? '1 : quo_reg[a][AXIS_BITS];
            for (int k = 0; k < AXIS_BITS; k++) begin
                code_next[3*k+a] = q[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i <= AXIS_BITS; i++) begin
            if (rdy[i]) begin
                for (int a = 0; a < 3; a++) begin
                    rem_reg[a][i] <= rem_next[a][i];
                    quo_reg[a][i] <= quo_next[a][i];
                    hi_reg[a][i]  <= hi_next[a][i];
                end
            end
        end
        if (rdy[NS-1]) begin
            code_reg <= code_next;
        end
    end

    assign m_morton_code = code_reg;

endmodule

// ----- test/tb.sv -----
module tb;
    import mce3d_pkg::*;

    localparam int unsigned AXIS  = AXIS_BITS_DEF;
    localparam int unsigned FRAC  = FRAC_BITS_DEF;
    localparam int unsigned CODE_W = 3 * AXIS;
    localparam int unsigned LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 155;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    world_t            cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    coord_t            s_coord_x = '0;
    coord_t            s_coord_y = '0;
    coord_t            s_coord_z = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CODE_W-1:0] m_morton_code;

    point_t            pending_points[$];
    logic [CODE_W-1:0] predicted_codes[$];
    world_t            cur_world = WORLD_SIZE_RST;
    int unsigned       mismatches = 0;
    int unsigned       cycles = 0;
    int unsigned       in_flight = 0;

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit long_hold_arm = 1'b0;
    bit long_hold_seen = 1'b0;
    int tx_gap = 0;
    int rx_stall = 0;
    int rx_hold = 0;

    morton_code_3d_encoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_morton_code (m_morton_code)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Map one coordinate into the world cube and quantize to AXIS bits.
    function automatic logic [AXIS-1:0] quantize_axis(coord_t c, world_t w);
        longint wd;
        longint num;
        longint den;
        longint q;
        wd  = (w == '0) ? 64'sd1 : longint'(w);
        num = 2 * longint'(c) + (wd <<< FRAC);
        den = wd <<< (FRAC + 1);
        if (num <= 0)
            return '0;
        if (num >= den)
            return '1;
        q = (num <<< AXIS) / den;
        if (q > longint'((64'd1 << AXIS) - 1))
            return '1;
        return q[AXIS-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] morton_of(point_t p, world_t w);
        logic [AXIS-1:0]   qx;
        logic [AXIS-1:0]   qy;
        logic [AXIS-1:0]   qz;
        logic [CODE_W-1:0] code;
        qx = quantize_axis(p.x, w);
        qy = quantize_axis(p.y, w);
        qz = quantize_axis(p.z, w);
        code = '0;
        for (int k = 0; k < AXIS; k++) begin
            code[3*k]   = qx[k];
            code[3*k+1] = qy[k];
            code[3*k+2] = qz[k];
        end
        return code;
    endfunction

    // Mostly inside the world, some near the faces, some anywhere.
    function automatic coord_t rand_coord(world_t w);
        longint half;
        longint v;
        half = ((w == '0) ? 64'sd1 : longint'(w)) * 128;
        case ($urandom_range(0, 9))
            0, 1: v = longint'($urandom);
            2: v = ($urandom_range(0, 1) ? half : -half) + int'($urandom_range(0, 6)) - 3;
            default: v = -half + longint'($urandom_range(0, 2 * half));
        endcase
        return coord_t'(v);
    endfunction

    task automatic add_point(coord_t x, coord_t y, coord_t z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points = {pending_points, p};
    endtask

    // in_flight counts items taken from the queue whose result is not yet back
    task automatic wait_drained();
        while (pending_points.size() != 0 || in_flight != 0)
            @(posedge aclk);
    endtask

    // World size may only change with the pipe empty.
    task automatic set_world(world_t w);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        cur_world    = w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Input driver
    always @(posedge aclk) begin : driver_p
        point_t p;
        logic   nv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                p.x = s_coord_x;
                p.y = s_coord_y;
                p.z = s_coord_z;
                predicted_codes = {predicted_codes, morton_of(p, cur_world)};
            end
            if (!s_valid || s_ready) begin
                nv = 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_points.size() != 0) begin
                    p = pending_points.pop_front();
                    in_flight++;
                    s_coord_x <= p.x;
                    s_coord_y <= p.y;
                    s_coord_z <= p.z;
                    nv = 1'b1;
                    if (tx_idle_en && $urandom_range(0, 7) == 0)
                        tx_gap = $urandom_range(1, 14);
                end
                s_valid <= nv;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin : monitor_p
        logic [CODE_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (predicted_codes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item, morton code %h", $time, m_morton_code);
                end else begin
                    want = predicted_codes.pop_front();
                    if (in_flight != 0)
                        in_flight--;
                    if (m_morton_code !== want) begin
                        mismatches++;
                        $display("%0t: morton code mismatch, expected %h, actual %h",
                                 $time, want, m_morton_code);
                    end
                end
            end
            if (long_hold_arm && !long_hold_seen) begin
                long_hold_seen = 1'b1;
                rx_hold = 300;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 9) == 0)
                    rx_stall = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus_p
        world_t worlds[8];
        world_t w;
        worlds = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd1000};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;

        // Directed points at the reset world size of 1000 (half edge 128000)
        add_point(32'sd0, 32'sd0, 32'sd0);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_point(-32'sd128000, -32'sd127999, -32'sd128001);
        add_point(32'sd128000, 32'sd127999, 32'sd128001);
        add_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        add_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
        add_point(32'sd1, -32'sd1, 32'sd256);
        // Zero world acts as one: half edge is 128
        set_world(16'd0);
        add_point(32'sd0, 32'sd0, 32'sd0);
        add_point(32'sd128, -32'sd128, 32'sd127);
        add_point(32'sd129, -32'sd129, -32'sd127);
        add_point(32'sd1, 32'sd2, 32'sd3);
        // Largest world: half edge 8388480
        set_world(16'd65535);
        add_point(32'sd8388480, -32'sd8388480, 32'sd0);
        add_point(32'sd8388479, -32'sd8388479, 32'sd8388481);
        add_point(32'h7fff_ffff, 32'h8000_0000, -32'sd8388481);
        add_point(32'sd1, -32'sd1, 32'sd0);

        for (int ph = 0; ph < 8; ph++) begin
            w = worlds[ph];
            if (ph == 2 || ph == 3 || ph == 5)
                w = world_t'($urandom_range(1, 65535));
            set_world(w);
            tx_idle_en <= (ph != 3 && ph != 7);
            rx_idle_en <= (ph != 7);
            if (ph == 3)
                long_hold_arm <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_point(rand_coord(w), rand_coord(w), rand_coord(w));
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
